// ===== design/pis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types, constants and helpers of the particle integration step.
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int AXES       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_FACTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_LIMIT  = 2'd2;

    localparam logic [30:0] INVERSE_MASS_RST = 31'd65536;
    localparam logic [16:0] DRAG_FACTOR_RST  = 17'd65536;
    localparam logic [30:0] FORCE_LIMIT_RST  = 31'd655360;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_CALC3
    } pis_state_t;

    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic commit;
    } pis_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/pis_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_in_if
// Request channel carrying one particle state and time step.
// ----------------------------------------------------------------------------
interface pis_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [16:0]        step_time;

    modport source (
        output valid, pos_x, pos_y, pos_z, force_x, force_y, force_z, step_time,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, force_x, force_y, force_z, step_time,
        output ready
    );
endinterface

// ===== design/pis_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_out_if
// Result channel carrying predicted position and new velocity.
// ----------------------------------------------------------------------------
interface pis_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;

    modport source (
        output valid, next_x, next_y, next_z, speed_x, speed_y, speed_z,
        input  ready
    );

    modport sink (
        input  valid, next_x, next_y, next_z, speed_x, speed_y, speed_z,
        output ready
    );
endinterface

// ===== design/pis_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface pis_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pis_pkg::CFG_IDX_W-1:0]    index;
    logic [pis_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== design/pis_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_ctrl
// Sequencer: load, two compute steps, commit into the result register.
// ----------------------------------------------------------------------------
module pis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pis_pkg::pis_cmd_t cmd
);

    pis_pkg::pis_state_t state_reg;
    pis_pkg::pis_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pis_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pis_pkg::ST_CALC1;
                end
            end
            pis_pkg::ST_CALC1: state_next = pis_pkg::ST_CALC2;
            pis_pkg::ST_CALC2: state_next = pis_pkg::ST_CALC3;
            pis_pkg::ST_CALC3:
            begin
                if (out_free)
                begin
                    state_next = pis_pkg::ST_IDLE;
                end
            end
            default: state_next = pis_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            pis_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pis_pkg::ST_CALC1: cmd.step1 = 1'b1;
            pis_pkg::ST_CALC2: cmd.step2 = 1'b1;
            pis_pkg::ST_CALC3: cmd.commit = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pis_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == pis_pkg::ST_CALC1)
        else $error("accepted request did not start the sequence");

    a_rise_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == pis_pkg::ST_CALC3)
        else $error("result raised without a completed sequence");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pis_pkg::ST_CALC3 && out_valid_reg && !out_ready)
            |=> (state_reg == pis_pkg::ST_CALC3 && out_valid_reg))
        else $error("commit overwrote an untaken result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pis_pkg::ST_CALC1 || state_reg == pis_pkg::ST_CALC2)
            |=> !in_ready)
        else $error("request accepted mid-sequence");

endmodule

// ===== design/pis_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_datapath
// Per-axis drag, position prediction, force clamp and velocity update.
// ----------------------------------------------------------------------------
module pis_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pis_pkg::pis_cmd_t               cmd,
    input  logic                            cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pis_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [31:0]              pos_in   [pis_pkg::AXES],
    input  logic signed [31:0]              force_in [pis_pkg::AXES],
    input  logic [16:0]                     step_time,
    output logic signed [31:0]              next_pos [pis_pkg::AXES],
    output logic signed [31:0]              speed    [pis_pkg::AXES]
);

    localparam logic signed [49:0] HALF16  = 50'sd32768;
    localparam logic signed [50:0] HALF17  = 51'sd65536;
    localparam logic signed [63:0] ACC_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic [30:0]        inv_mass_reg;
    logic [16:0]        drag_reg;
    logic [30:0]        limit_reg;
    logic signed [31:0] vel_reg    [pis_pkg::AXES];
    logic signed [31:0] accel_reg  [pis_pkg::AXES];

    logic signed [31:0] pos_reg    [pis_pkg::AXES];
    logic signed [31:0] force_reg  [pis_pkg::AXES];
    logic [16:0]        t_reg;
    logic signed [31:0] fclamp_reg [pis_pkg::AXES];
    logic signed [31:0] vd_reg     [pis_pkg::AXES];
    logic signed [32:0] at_reg     [pis_pkg::AXES];
    logic signed [32:0] vt_reg     [pis_pkg::AXES];
    logic signed [32:0] hatt_reg   [pis_pkg::AXES];
    logic signed [31:0] acc_reg    [pis_pkg::AXES];
    logic signed [31:0] next_reg   [pis_pkg::AXES];
    logic signed [31:0] speed_reg  [pis_pkg::AXES];

    logic signed [31:0] fclamp_next [pis_pkg::AXES];
    logic signed [31:0] vd_next     [pis_pkg::AXES];
    logic signed [32:0] at_next     [pis_pkg::AXES];
    logic signed [32:0] vt_next     [pis_pkg::AXES];
    logic signed [32:0] hatt_next   [pis_pkg::AXES];
    logic signed [31:0] acc_next    [pis_pkg::AXES];
    logic signed [31:0] pos_next    [pis_pkg::AXES];
    logic signed [31:0] vel_next    [pis_pkg::AXES];

    logic signed [17:0] t_s;
    logic signed [17:0] drag_s;
    logic signed [31:0] invm_s;
    logic signed [32:0] lim_s;
    logic signed [32:0] nlim_s;

    logic signed [32:0] f_ext   [pis_pkg::AXES];
    logic signed [49:0] vd_sum  [pis_pkg::AXES];
    logic signed [49:0] at_sum  [pis_pkg::AXES];
    logic signed [49:0] vt_sum  [pis_pkg::AXES];
    logic signed [50:0] ha_sum  [pis_pkg::AXES];
    logic signed [63:0] acc_sum [pis_pkg::AXES];
    logic signed [63:0] acc_shr [pis_pkg::AXES];
    logic signed [49:0] dv_sum  [pis_pkg::AXES];
    logic signed [34:0] p_sum   [pis_pkg::AXES];
    logic signed [34:0] v_sum   [pis_pkg::AXES];
    logic signed [33:0] vd_rnd  [pis_pkg::AXES];
    logic signed [33:0] dv_rnd  [pis_pkg::AXES];

    assign t_s    = $signed({1'b0, t_reg});
    assign drag_s = $signed({1'b0, drag_reg});
    assign invm_s = $signed({1'b0, inv_mass_reg});
    assign lim_s  = $signed({2'b00, limit_reg});
    assign nlim_s = -lim_s;

    always_comb
    begin
        for (int i = 0; i < pis_pkg::AXES; i++)
        begin
            // step 1: drag, old acceleration times dt, force clamp
            vd_sum[i]  = (vel_reg[i] * drag_s) + HALF16;
            vd_rnd[i]  = vd_sum[i][49:16];
            vd_next[i] = pis_pkg::sat32({{30{vd_rnd[i][33]}}, vd_rnd[i]});
            at_sum[i]  = (accel_reg[i] * t_s) + HALF16;
            at_next[i] = at_sum[i][48:16];
            f_ext[i]   = {force_reg[i][31], force_reg[i]};
            if (f_ext[i] < nlim_s)
            begin
                fclamp_next[i] = nlim_s[31:0];
            end
            else if (f_ext[i] > lim_s)
            begin
                fclamp_next[i] = lim_s[31:0];
            end
            else
            begin
                fclamp_next[i] = force_reg[i];
            end

            // step 2: velocity and half acceleration terms, new acceleration
            vt_sum[i]   = (vd_reg[i] * t_s) + HALF16;
            vt_next[i]  = vt_sum[i][48:16];
            ha_sum[i]   = (at_reg[i] * t_s) + HALF17;
            hatt_next[i] = ha_sum[i][49:17];
            acc_sum[i]  = (fclamp_reg[i] * invm_s) + ACC_HALF;
            acc_shr[i]  = acc_sum[i] >>> FRAC_BITS;
            acc_next[i] = pis_pkg::sat32(acc_shr[i]);

            // step 3: position sum and velocity update
            p_sum[i]    = {{3{pos_reg[i][31]}}, pos_reg[i]}
                        + {{2{vt_reg[i][32]}}, vt_reg[i]}
                        + {{2{hatt_reg[i][32]}}, hatt_reg[i]};
            pos_next[i] = pis_pkg::sat32({{29{p_sum[i][34]}}, p_sum[i]});
            dv_sum[i]   = (acc_reg[i] * t_s) + HALF16;
            dv_rnd[i]   = dv_sum[i][49:16];
            v_sum[i]    = {{3{vd_reg[i][31]}}, vd_reg[i]}
                        + {dv_rnd[i][33], dv_rnd[i]};
            vel_next[i] = pis_pkg::sat32({{29{v_sum[i][34]}}, v_sum[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg <= pis_pkg::INVERSE_MASS_RST;
            drag_reg     <= pis_pkg::DRAG_FACTOR_RST;
            limit_reg    <= pis_pkg::FORCE_LIMIT_RST;
            for (int i = 0; i < pis_pkg::AXES; i++)
            begin
                vel_reg[i]   <= '0;
                accel_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pis_pkg::REG_INVERSE_MASS: inv_mass_reg <= cfg_data;
                    pis_pkg::REG_DRAG_FACTOR:  drag_reg     <= cfg_data[16:0];
                    pis_pkg::REG_FORCE_LIMIT:  limit_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < pis_pkg::AXES; i++)
                begin
                    vel_reg[i]   <= vel_next[i];
                    accel_reg[i] <= acc_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg <= step_time;
        end
        for (int i = 0; i < pis_pkg::AXES; i++)
        begin
            if (cmd.load)
            begin
                pos_reg[i]   <= pos_in[i];
                force_reg[i] <= force_in[i];
            end
            if (cmd.step1)
            begin
                vd_reg[i]     <= vd_next[i];
                at_reg[i]     <= at_next[i];
                fclamp_reg[i] <= fclamp_next[i];
            end
            if (cmd.step2)
            begin
                vt_reg[i]   <= vt_next[i];
                hatt_reg[i] <= hatt_next[i];
                acc_reg[i]  <= acc_next[i];
            end
            if (cmd.commit)
            begin
                next_reg[i]  <= pos_next[i];
                speed_reg[i] <= vel_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < pis_pkg::AXES; i++)
        begin
            next_pos[i] = next_reg[i];
            speed[i]    = speed_reg[i];
        end
    end

endmodule

// ===== design/particle_integration_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_integration_step
// One time step of a 3D particle: drag, position prediction, force clamp,
// acceleration and velocity update, all Q16.16 with saturation.
//
//   channel    role   handshake        payload
//   particle   sink   valid / ready    pos_x..z, force_x..z, step_time
//   result     source valid / ready    next_x..z, speed_x..z
//   cfg        sink   valid / ready    index, data (ready always high)
//
// one request at a time, accepted in idle: accept, then three compute steps of the
// sequencer, all three axes side by side on their own multipliers
// the result register holds a finished result while the next request is taken
// a full result register that is not drained stalls the last step
// reset clears velocity, acceleration and registers to their defaults
// ----------------------------------------------------------------------------
module particle_integration_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pis_in_if.sink    particle,
    pis_out_if.source result,
    pis_cfg_if.sink   cfg
);

    pis_pkg::pis_cmd_t  cmd;
    logic signed [31:0] pos_in   [pis_pkg::AXES];
    logic signed [31:0] force_in [pis_pkg::AXES];
    logic signed [31:0] next_pos [pis_pkg::AXES];
    logic signed [31:0] speed    [pis_pkg::AXES];

    assign cfg.ready = 1'b1;

    assign pos_in[0]   = particle.pos_x;
    assign pos_in[1]   = particle.pos_y;
    assign pos_in[2]   = particle.pos_z;
    assign force_in[0] = particle.force_x;
    assign force_in[1] = particle.force_y;
    assign force_in[2] = particle.force_z;

    assign result.next_x  = next_pos[0];
    assign result.next_y  = next_pos[1];
    assign result.next_z  = next_pos[2];
    assign result.speed_x = speed[0];
    assign result.speed_y = speed[1];
    assign result.speed_z = speed[2];

    pis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (particle.valid),
        .in_ready  (particle.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    pis_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .pos_in    (pos_in),
        .force_in  (force_in),
        .step_time (particle.step_time),
        .next_pos  (next_pos),
        .speed     (speed)
    );

endmodule
